@@ rtl/core/sf3_pkg.sv @@
// shared constants for the 3x3 sharpen filter
// field widths, configuration register codes and reset values
// no dependencies
`default_nettype none

package sf3_pkg;

	// default limits, handed to the top-level parameters
	localparam int DEF_MAX_WIDTH    = 1024;
	localparam int DEF_MAX_CHANNELS = 4;
	localparam int DEF_MAX_HEIGHT   = 2048;

	// payload field widths
	localparam int SAMPLE_W   = 8;
	localparam int ROW_IDX_W  = 11;
	localparam int BYTE_COL_W = 12;

	// configuration register widths
	localparam int IMG_W_BITS = 11;
	localparam int IMG_H_BITS = 12;
	localparam int CH_BITS    = 3;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

	localparam logic [IMG_W_BITS-1:0] RST_IMAGE_WIDTH   = 11'd640;
	localparam logic [IMG_H_BITS-1:0] RST_IMAGE_HEIGHT  = 12'd480;
	localparam logic [CH_BITS-1:0]    RST_CHANNEL_COUNT = 3'd3;

	// smallest legal image dimension and channel count
	localparam int MIN_DIM      = 3;
	localparam int MIN_CHANNELS = 1;

	// saturation limit of the result
	localparam int PIX_MAX = 255;

endpackage

`default_nettype wire

@@ rtl/core/sf3_if.sv @@
// valid/ready stream interfaces for the sharpen filter
// input byte channel and result channel; depends on sf3_pkg
`default_nettype none

interface sf3_in_if import sf3_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface sf3_out_if import sf3_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [SAMPLE_W-1:0]   value;
	logic [ROW_IDX_W-1:0]  row_index;
	logic [BYTE_COL_W-1:0] byte_column;
	logic                  frame_end;

	modport source (output valid, output value, output row_index, output byte_column,
		output frame_end, input ready);
	modport sink   (input valid, input value, input row_index, input byte_column,
		input frame_end, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sf3_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module sf3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/sf3_cfg_cnt.sv @@
// configuration registers, clamping and raster position counters
// depends on sf3_pkg
`default_nettype none

module sf3_cfg_cnt import sf3_pkg::*; #(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
	localparam int AW   = $clog2(MAX_WIDTH * MAX_CHANNELS),
	localparam int RBW  = $clog2(MAX_WIDTH * MAX_CHANNELS + 1),
	localparam int CHW  = $clog2(MAX_CHANNELS + 1),
	localparam int HCLW = $clog2(MAX_HEIGHT + 1),
	localparam int RW   = $clog2(MAX_HEIGHT)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  reg_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	input  wire logic                  accept,
	output logic      [AW-1:0]         col,
	output logic      [RW-1:0]         row,
	output logic      [CHW-1:0]        ch,
	output logic      [RBW-1:0]        row_bytes,
	output logic      [HCLW-1:0]       height
);

	localparam int WCLW = $clog2(MAX_WIDTH + 1);

	logic [IMG_W_BITS-1:0] img_w_q;
	logic [IMG_H_BITS-1:0] img_h_q;
	logic [CH_BITS-1:0]    ch_cnt_q;
	logic [AW-1:0]         col_q;
	logic [RW-1:0]         row_q;
	logic [WCLW-1:0]       w_cl;
	logic [RBW-1:0]        col_inc;
	logic [RW:0]           row_inc;

	always_comb begin
		if (img_w_q < IMG_W_BITS'(MIN_DIM)) begin
			w_cl = WCLW'(MIN_DIM);
		end else if (int'(img_w_q) > MAX_WIDTH) begin
			w_cl = WCLW'(MAX_WIDTH);
		end else begin
			w_cl = WCLW'(img_w_q);
		end
		if (img_h_q < IMG_H_BITS'(MIN_DIM)) begin
			height = HCLW'(MIN_DIM);
		end else if (int'(img_h_q) > MAX_HEIGHT) begin
			height = HCLW'(MAX_HEIGHT);
		end else begin
			height = HCLW'(img_h_q);
		end
		if (ch_cnt_q < CH_BITS'(MIN_CHANNELS)) begin
			ch = CHW'(MIN_CHANNELS);
		end else if (int'(ch_cnt_q) > MAX_CHANNELS) begin
			ch = CHW'(MAX_CHANNELS);
		end else begin
			ch = CHW'(ch_cnt_q);
		end
	end

	assign row_bytes = RBW'(w_cl) * RBW'(ch);
	assign col_inc   = RBW'(col_q) + RBW'(1);
	assign row_inc   = (RW+1)'(row_q) + (RW+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q  <= RST_IMAGE_WIDTH;
			img_h_q  <= RST_IMAGE_HEIGHT;
			ch_cnt_q <= RST_CHANNEL_COUNT;
			col_q    <= '0;
			row_q    <= '0;
		end else if (wr_en) begin
			// any known register write restarts the frame
			case (reg_index)
				REG_IMAGE_WIDTH: begin
					img_w_q <= wr_data[IMG_W_BITS-1:0];
					col_q   <= '0;
					row_q   <= '0;
				end
				REG_IMAGE_HEIGHT: begin
					img_h_q <= wr_data[IMG_H_BITS-1:0];
					col_q   <= '0;
					row_q   <= '0;
				end
				REG_CHANNEL_COUNT: begin
					ch_cnt_q <= wr_data[CH_BITS-1:0];
					col_q    <= '0;
					row_q    <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (col_inc >= row_bytes) begin
				col_q <= '0;
				if (row_inc >= (RW+1)'(height)) begin
					row_q <= '0;
				end else begin
					row_q <= row_inc[RW-1:0];
				end
			end else begin
				col_q <= col_inc[AW-1:0];
			end
		end
	end

	assign col = col_q;
	assign row = row_q;

endmodule

`default_nettype wire

@@ rtl/core/sf3_datapath.sv @@
// read-modify-write stage, neighbour windows, kernel arithmetic, result register
// depends on sf3_pkg and sf3_if
`default_nettype none

module sf3_datapath import sf3_pkg::*; #(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
	localparam int AW   = $clog2(MAX_WIDTH * MAX_CHANNELS),
	localparam int RBW  = $clog2(MAX_WIDTH * MAX_CHANNELS + 1),
	localparam int CHW  = $clog2(MAX_CHANNELS + 1),
	localparam int HCLW = $clog2(MAX_HEIGHT + 1),
	localparam int RW   = $clog2(MAX_HEIGHT)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	sf3_in_if.sink                   pixel,
	sf3_out_if.source                result,
	input  wire logic [AW-1:0]       col,
	input  wire logic [RW-1:0]       row,
	input  wire logic [CHW-1:0]      ch,
	input  wire logic [RBW-1:0]      row_bytes,
	input  wire logic [HCLW-1:0]     height,
	input  wire logic [SAMPLE_W-1:0] prior_rd,
	input  wire logic [SAMPLE_W-1:0] older_rd,
	output logic                     accept,
	output logic                     ram_we,
	output logic      [AW-1:0]       ram_waddr,
	output logic      [SAMPLE_W-1:0] prior_wd,
	output logic      [SAMPLE_W-1:0] older_wd
);

	localparam int WD  = 2 * MAX_CHANNELS;
	localparam int CIW = $clog2(WD);

	logic                  v_s1;
	logic [SAMPLE_W-1:0]   smp_s1;
	logic [AW-1:0]         col_s1;
	logic [RW-1:0]         row_s1;

	logic [SAMPLE_W-1:0]   cen_win_q [WD];

	logic                  res_v_q;
	logic [SAMPLE_W-1:0]   res_value_q;
	logic [ROW_IDX_W-1:0]  res_row_q;
	logic [BYTE_COL_W-1:0] res_col_q;
	logic                  res_end_q;

	logic [CIW-1:0]        ch_w;
	logic [CIW-1:0]        idx_near;
	logic [CIW-1:0]        idx_far;
	logic [SAMPLE_W+2:0]   gain_term;
	logic [SAMPLE_W+1:0]   neg_sum;
	logic signed [SAMPLE_W+3:0] acc;
	logic [SAMPLE_W-1:0]   sat;
	logic                  emit;
	logic                  adv;
	logic                  last_byte;
	logic [RW-1:0]         out_row;

	// the prior row is read one pixel ahead: the centre was read one pixel back,
	// its left neighbour two pixels back
	assign ch_w     = CIW'(ch);
	assign idx_near = ch_w - CIW'(1);
	assign idx_far  = (ch_w << 1) - CIW'(1);

	// 5 * centre - (left + right + up + down); right is the byte just read
	assign gain_term = ((SAMPLE_W+3)'(cen_win_q[idx_near]) << 2)
		+ (SAMPLE_W+3)'(cen_win_q[idx_near]);
	assign neg_sum = (SAMPLE_W+2)'(cen_win_q[idx_far]) + (SAMPLE_W+2)'(prior_rd)
		+ (SAMPLE_W+2)'(older_rd) + (SAMPLE_W+2)'(smp_s1);
	assign acc = $signed({1'b0, gain_term}) - $signed({2'b00, neg_sum});

	always_comb begin
		if (acc < 0) begin
			sat = '0;
		end else if (acc > (SAMPLE_W+4)'(PIX_MAX)) begin
			sat = SAMPLE_W'(PIX_MAX);
		end else begin
			sat = acc[SAMPLE_W-1:0];
		end
	end

	assign emit = (row_s1 >= RW'(2)) && ((RBW+1)'(col_s1) >= (RBW+1)'(ch))
		&& ((RBW+1)'(col_s1) + (RBW+1)'(ch) < (RBW+1)'(row_bytes));
	assign last_byte = ((HCLW+1)'(row_s1) + (HCLW+1)'(1) == (HCLW+1)'(height))
		&& ((RBW+1)'(col_s1) + (RBW+1)'(ch) + (RBW+1)'(1) == (RBW+1)'(row_bytes));
	assign out_row = row_s1 - RW'(1);

	assign adv          = v_s1 && (!emit || !res_v_q || result.ready);
	assign pixel.ready  = !v_s1 || adv;
	assign accept       = pixel.valid && pixel.ready;

	assign ram_we    = adv;
	assign ram_waddr = col_s1;
	assign prior_wd  = smp_s1;
	assign older_wd  = cen_win_q[idx_near];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv && emit) begin
				res_v_q <= 1'b1;
			end else if (result.ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_s1 <= pixel.sample;
			col_s1 <= col;
			row_s1 <= row;
		end
		if (adv) begin
			cen_win_q[0] <= prior_rd;
			for (int k = 1; k < WD; k++) begin
				cen_win_q[k] <= cen_win_q[k-1];
			end
		end
		if (adv && emit) begin
			res_value_q <= sat;
			res_row_q   <= ROW_IDX_W'(out_row);
			res_col_q   <= BYTE_COL_W'(col_s1);
			res_end_q   <= last_byte;
		end
	end

	assign result.valid       = res_v_q;
	assign result.value       = res_value_q;
	assign result.row_index   = res_row_q;
	assign result.byte_column = res_col_q;
	assign result.frame_end   = res_end_q;

endmodule

`default_nettype wire

@@ rtl/core/sharpen_filter_3x3.sv @@
// 3x3 sharpen filter, top level: one image byte per beat in, sharpened bytes out for the interior
// throughput: one byte per cycle unless stage 1 stalls; line stores: one read, one write per byte
// path: the byte below and its ram reads are registered into stage 1, then into the result
//   register; stage 1 stalls only while its result waits behind a full output register
// reset: counters and handshake state clear, registers take their defaults; line stores
//   stay uninitialized and need no clearing pass, every entry read for a result is rewritten first
`default_nettype none

module sharpen_filter_3x3 import sf3_pkg::*; #(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	sf3_in_if.sink                     pixel,
	sf3_out_if.source                  result,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  reg_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RBW   = $clog2(DEPTH + 1);
	localparam int CHW   = $clog2(MAX_CHANNELS + 1);
	localparam int HCLW  = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = $clog2(MAX_HEIGHT);

	// raster position of the next beat and the clamped geometry
	logic [AW-1:0]       col;
	logic [RW-1:0]       row;
	logic [CHW-1:0]      ch;
	logic [RBW-1:0]      row_bytes;
	logic [HCLW-1:0]     height;

	// prior row read address: one pixel ahead, wrapping to the row start
	logic [RBW:0]        ahead_sum;
	logic [AW-1:0]       prior_raddr;

	// line-store traffic: read at acceptance, written back when the byte leaves stage 1
	logic                accept;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [SAMPLE_W-1:0] prior_rd;
	logic [SAMPLE_W-1:0] older_rd;
	logic [SAMPLE_W-1:0] prior_wd;
	logic [SAMPLE_W-1:0] older_wd;

	sf3_cfg_cnt #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_HEIGHT   (MAX_HEIGHT)
	) u_cfg_cnt (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.reg_index (reg_index),
		.wr_data   (wr_data),
		.accept    (accept),
		.col       (col),
		.row       (row),
		.ch        (ch),
		.row_bytes (row_bytes),
		.height    (height)
	);

	// the right neighbour of the byte above; near the row end this wraps to the row start,
	// where the entry already holds the current row and feeds the next row's windows
	assign ahead_sum   = (RBW+1)'(col) + (RBW+1)'(ch);
	assign prior_raddr = (ahead_sum >= (RBW+1)'(row_bytes))
		? AW'(ahead_sum - (RBW+1)'(row_bytes)) : AW'(ahead_sum);

	// prior row: the row just above the incoming byte, read one pixel ahead
	sf3_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DEPTH)
	) u_prior_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (prior_wd),
		.rd_en   (accept),
		.rd_addr (prior_raddr),
		.rd_data (prior_rd)
	);

	// older row: two rows above, filled from what the prior row held
	sf3_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DEPTH)
	) u_older_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (older_wd),
		.rd_en   (accept),
		.rd_addr (col),
		.rd_data (older_rd)
	);

	// stage 1 takes ram data, shifts the neighbour window and fills the result register
	sf3_datapath #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_HEIGHT   (MAX_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel),
		.result    (result),
		.col       (col),
		.row       (row),
		.ch        (ch),
		.row_bytes (row_bytes),
		.height    (height),
		.prior_rd  (prior_rd),
		.older_rd  (older_rd),
		.accept    (accept),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.prior_wd  (prior_wd),
		.older_wd  (older_wd)
	);

	// write-back and the next reads never hit the same entry
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ram_we |-> col != ram_waddr && prior_raddr != ram_waddr)
		else $error("line store read and write hit the same entry");

	// a write to a known register restarts the frame
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && (reg_index == REG_IMAGE_WIDTH || reg_index == REG_IMAGE_HEIGHT
			|| reg_index == REG_CHANNEL_COUNT) |=> col == '0 && row == '0)
		else $error("position counters not cleared by register write");

	// the column counter stays inside the row
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		RBW'(col) < row_bytes)
		else $error("column counter beyond row length");

endmodule

`default_nettype wire
